@@ hdl/nfq_pkg.sv @@
// Shared types and constants for the nearest-first job queue.
`default_nettype none
package nfq_pkg;
  localparam int ID_W    = 16;
  localparam int COORD_W = 24;
  localparam int DIST_W  = 50;
  localparam int ENTRY_W = ID_W + 3 * COORD_W;
  localparam int KIND_W  = 3;
  localparam int IN_DATA_W  = ID_W + 6 * COORD_W;
  localparam int OUT_DATA_W = 72;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [DIST_W-1:0]  dist_t;

  typedef struct packed {
    coord_t          z;
    coord_t          y;
    coord_t          x;
    logic [ID_W-1:0] id;
  } entry_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DISCARDED = 3'd0,
    KIND_SELECTED  = 3'd1,
    KIND_EMPTY     = 3'd2,
    KIND_PUSH_OK   = 3'd3,
    KIND_PUSH_FULL = 3'd4
  } kind_t;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [7:0] REG_MAX_DIST_SQ    = 8'd0;
  localparam logic [7:0] REG_DISCARD_ENABLE = 8'd1;
endpackage
`default_nettype wire

@@ hdl/nfq_dist.sv @@
// Shared squared-distance unit: one multiplier, one axis per cycle.
`default_nettype none
module nfq_dist
  import nfq_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   start,
  input  wire entry_t ent,
  input  wire coord_t vx,
  input  wire coord_t vy,
  input  wire coord_t vz,
  output logic        done,
  output dist_t       dist_sq
);
  logic [1:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  dist_t       acc_r;
  dist_t       prod_r;
  coord_t      a, b;
  logic [COORD_W:0] diff, mag;
  logic [2*COORD_W+1:0] sq;

  always_comb begin
    case (cnt_r)
      2'd0: begin a = ent.x; b = vx; end
      2'd1: begin a = ent.y; b = vy; end
      default: begin a = ent.z; b = vz; end
    endcase
    diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    mag  = diff[COORD_W] ? (~diff + 1'b1) : diff;
    sq   = mag * mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == 2'd3);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 2'd0;
        acc_r  <= '0;
      end else if (busy_r) begin
        // product of the previous axis accumulates while the next one multiplies
        if (cnt_r != 2'd0) acc_r <= acc_r + prod_r;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
        end else begin
          prod_r <= sq[DIST_W-1:0];
          cnt_r  <= cnt_r + 2'd1;
        end
      end
    end
  end

  assign done    = done_r;
  assign dist_sq = acc_r;
endmodule
`default_nettype wire

@@ hdl/nearest_first_queue_with_range_discard_top.sv @@
// Nearest-first job queue: sequencer, job table memory and output register.
// Push: S_PUSH stores the job if there is room and loads the result. Pop: a scan of
// each stored job (table read, unit start, shared distance unit, decision), the final
// result, then a read and a write per job moved behind the selected one, plus
// output stalls; up to QUEUE_DEPTH+1 results. in_tready is high only while idle.
// Synchronous active-low reset empties the table, max_dist_sq=0, discard_enable=1.
`default_nettype none
module nearest_first_queue_with_range_discard_top
  import nfq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // job_id, job_x, job_y, job_z, viewer_x, viewer_y, viewer_z
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // opcode
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // result_id, result_dist_sq, zero pad
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // result_kind
  output logic [KIND_W-1:0]          out_tuser,
  output logic                       out_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [7:0]            cfg_index,
  input  wire logic [DIST_W-1:0]     cfg_data
);
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_PUSH = 9'b000000010,
    S_RD   = 9'b000000100,
    S_GO   = 9'b000001000,
    S_CALC = 9'b000010000,
    S_DEC  = 9'b000100000,
    S_FIN  = 9'b001000000,
    S_SH   = 9'b010000000,
    S_SHW  = 9'b100000000
  } state_t;

  state_t          state_r;
  dist_t           max_dist_r;
  logic            disc_en_r;
  logic [CW-1:0]   count_r, i_r, kept_r, j_r, best_idx_r;
  dist_t           best_d_r;
  logic [ID_W-1:0] best_id_r;
  entry_t          push_r;
  coord_t          vx_r, vy_r, vz_r;

  entry_t          mem [QUEUE_DEPTH];
  entry_t          rd_data_r;
  logic [AW-1:0]   rd_addr, wr_addr;
  entry_t          wr_data;
  logic            wr_en;

  logic            dist_start, dist_done;
  dist_t           cur_dist;
  logic            slot_free;
  logic            drop;
  logic            ov_load;

  logic            ov_r, olast_r;
  kind_t           okind_r;
  logic [ID_W-1:0] oid_r;
  dist_t           odist_r;

  nfq_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (dist_start),
    .ent     (rd_data_r),
    .vx      (vx_r),
    .vy      (vy_r),
    .vz      (vz_r),
    .done    (dist_done),
    .dist_sq (cur_dist)
  );

  assign slot_free  = !ov_r || out_tready;
  assign dist_start = (state_r == S_GO);
  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign drop       = disc_en_r && (cur_dist > max_dist_r);
  assign ov_load    = slot_free && (state_r == S_PUSH || state_r == S_FIN ||
                                    (state_r == S_DEC && drop));

  always_comb begin
    rd_addr = i_r[AW-1:0];
    if (state_r == S_SH || state_r == S_SHW) rd_addr = j_r[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = count_r[AW-1:0];
    wr_data = push_r;
    case (state_r)
      S_PUSH: wr_en = slot_free && (count_r != DEPTH_C);
      S_DEC: begin
        wr_en   = !drop;
        wr_addr = kept_r[AW-1:0];
        wr_data = rd_data_r;
      end
      S_SHW: begin
        wr_en   = 1'b1;
        wr_addr = AW'(j_r - 1'b1);
        wr_data = rd_data_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      max_dist_r <= '0;
      disc_en_r  <= 1'b1;
      count_r    <= '0;
      ov_r       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_MAX_DIST_SQ) max_dist_r <= cfg_data;
        else if (cfg_index == REG_DISCARD_ENABLE) disc_en_r <= cfg_data[0];
      end
      if (ov_load) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            push_r <= entry_t'(in_tdata[ENTRY_W-1:0]);
            vx_r   <= in_tdata[ENTRY_W +: COORD_W];
            vy_r   <= in_tdata[ENTRY_W+COORD_W +: COORD_W];
            vz_r   <= in_tdata[ENTRY_W+2*COORD_W +: COORD_W];
            i_r    <= '0;
            kept_r <= '0;
            if (in_tuser == OP_PUSH) state_r <= S_PUSH;
            else if (count_r == '0) state_r <= S_FIN;
            else state_r <= S_RD;
          end
        end
        S_PUSH: begin
          if (slot_free) begin
            olast_r <= 1'b1;
            oid_r   <= push_r.id;
            odist_r <= '0;
            if (count_r == DEPTH_C) begin
              okind_r <= KIND_PUSH_FULL;
            end else begin
              okind_r <= KIND_PUSH_OK;
              count_r <= count_r + 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        S_RD:   state_r <= S_GO;
        S_GO:   state_r <= S_CALC;
        S_CALC: if (dist_done) state_r <= S_DEC;
        S_DEC: begin
          if (drop) begin
            if (slot_free) begin
              olast_r <= 1'b0;
              okind_r <= KIND_DISCARDED;
              oid_r   <= rd_data_r.id;
              odist_r <= cur_dist;
              i_r     <= i_r + 1'b1;
              state_r <= (i_r + 1'b1 < count_r) ? S_RD : S_FIN;
            end
          end else begin
            // first kept job seeds the minimum; ties keep the earlier one
            if (kept_r == '0 || cur_dist < best_d_r) begin
              best_d_r   <= cur_dist;
              best_idx_r <= kept_r;
              best_id_r  <= rd_data_r.id;
            end
            kept_r  <= kept_r + 1'b1;
            i_r     <= i_r + 1'b1;
            state_r <= (i_r + 1'b1 < count_r) ? S_RD : S_FIN;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            olast_r <= 1'b1;
            if (kept_r == '0) begin
              okind_r <= KIND_EMPTY;
              oid_r   <= '0;
              odist_r <= '0;
              count_r <= '0;
              state_r <= S_IDLE;
            end else begin
              okind_r <= KIND_SELECTED;
              oid_r   <= best_id_r;
              odist_r <= best_d_r;
              count_r <= kept_r - 1'b1;
              j_r     <= best_idx_r + 1'b1;
              state_r <= (best_idx_r + 1'b1 < kept_r) ? S_SH : S_IDLE;
            end
          end
        end
        S_SH: state_r <= S_SHW;
        S_SHW: begin
          j_r     <= j_r + 1'b1;
          state_r <= (j_r + 1'b1 < kept_r) ? S_SH : S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {{(OUT_DATA_W-DIST_W-ID_W){1'b0}}, odist_r, oid_r};
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
endmodule
`default_nettype wire

@@ hdl/nfq_checker.sv @@
// Port-level checks for the nearest-first job queue, bound to the top level.
`default_nettype none
module nfq_checker
  import nfq_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic [KIND_W-1:0]     out_tuser,
  input wire logic                  out_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_push_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_PUSH_OK || out_tuser == KIND_PUSH_FULL) |-> out_tlast)
    else $error("push result not last");

  a_disc_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_DISCARDED |-> !out_tlast)
    else $error("discard result marked last");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_EMPTY |-> out_tdata == '0)
    else $error("empty result carries data");
endmodule

bind nearest_first_queue_with_range_discard_top nfq_checker u_nfq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
